@@ design/piecewise_linear_setpoint_profile_defines.svh @@
// Assertion macros shared by the setpoint profile modules.
`ifndef PIECEWISE_LINEAR_SETPOINT_PROFILE_DEFINES_SVH
`define PIECEWISE_LINEAR_SETPOINT_PROFILE_DEFINES_SVH

// Same-cycle implication, clocked on clk and switched off during reset.
`define PSP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and switched off during reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/psp_pkg.sv @@
// Shared types, constants and codes of the setpoint profile block.
`default_nettype none
package psp_pkg;
	localparam int MAX_POINTS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	// Seconds are ms * RECIP_1000 >> RECIP_SH, exact for every 32-bit millisecond count.
	localparam logic [28:0] RECIP_1000 = 29'd274877907;
	localparam int RECIP_SH = 38;
	localparam int DVSR_W = 20;
	localparam int DIVD_W = 37;
	localparam int DIV_STEPS = DIVD_W;
	localparam int DCNT_W = $clog2(DIV_STEPS + 1);
	localparam int ELAP_W = 23;

	typedef enum logic [2:0] {
		OP_LOAD   = 3'd0,
		OP_COMMIT = 3'd1,
		OP_DELETE = 3'd2,
		OP_START  = 3'd3,
		OP_CLEAR  = 3'd4,
		OP_QUERY  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FEW    = 3'd1,
		ST_RANGE  = 3'd2,
		ST_ORDER  = 3'd3,
		ST_NOPROF = 3'd4
	} status_t;

	typedef enum logic {
		REG_TEMP_MIN = 1'b0,
		REG_TEMP_MAX = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_DIV_E,
		S_Q_RD,
		S_Q_CHK,
		S_MUL,
		S_DIV_I,
		S_C_RD,
		S_C_CHK,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic div_elapsed;
		logic elapsed_ld;
		logic div_interp;
		logic cnt_clr;
		logic rd;
		logic step;
		logic c_range;
		logic c_order;
		logic c_ok;
		logic q_take;
		logic q_last;
		logic mul;
		logic fin;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic total_bad;
		logic run_ok;
		logic first;
		logic temp_bad;
		logic le_prev;
		logic hit;
		logic last;
		logic div_busy;
	} stat_t;
endpackage
`default_nettype wire

@@ design/piecewise_linear_setpoint_profile.sv @@
// Load, delete, start, clear and commits with a bad point count go from accept through
// execution to the result. A commit reads and checks each point in turn; a query scales
// milliseconds to seconds, reads and checks points, then multiplies and divides for a slope.
// One word is in flight at a time; the next is accepted once the result is registered.
// Reset is asynchronous and active low; it clears control state and sets the limits to
// -1600 and 8000. Point memory is not cleared and reads as unknown until loaded.
`default_nettype none
module piecewise_linear_setpoint_profile (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         op,
	input  wire logic [3:0]         point_index,
	input  wire logic [19:0]        point_time,
	input  wire logic signed [15:0] point_temp,
	input  wire logic [4:0]         point_total,
	input  wire logic               end_mode_in,
	input  wire logic [31:0]        now_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic                    run_on,
	output logic                    completed,
	output logic                    end_mode_out,
	output logic signed [15:0]      setpoint
);
	import psp_pkg::*;

	// Temperature limits used when a profile is committed.
	logic signed [15:0] temp_min_q;
	logic signed [15:0] temp_max_q;
	logic               wr_en;
	cmd_t               cmd;
	stat_t              stat;

	// The register bus never waits; a write lands in the access phase.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q <= -16'sd1600;
			temp_max_q <= 16'sd8000;
		end else if (wr_en) begin
			unique case (reg_t'(paddr[2]))
				REG_TEMP_MIN: temp_min_q <= pwdata[15:0];
				REG_TEMP_MAX: temp_max_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the limit sign-extended to the bus width.
	always_comb begin
		unique case (reg_t'(paddr[2]))
			REG_TEMP_MIN: prdata = {{16{temp_min_q[15]}}, temp_min_q};
			REG_TEMP_MAX: prdata = {{16{temp_max_q[15]}}, temp_max_q};
			default:      prdata = '0;
		endcase
	end

	// The controller steps each word through the datapath and hands over the result.
	psp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	psp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_min      (temp_min_q),
		.cfg_max      (temp_max_q),
		.op           (op),
		.point_index  (point_index),
		.point_time   (point_time),
		.point_temp   (point_temp),
		.point_total  (point_total),
		.end_mode_in  (end_mode_in),
		.now_ms       (now_ms),
		.status       (status),
		.run_on       (run_on),
		.completed    (completed),
		.end_mode_out (end_mode_out),
		.setpoint     (setpoint)
	);
endmodule
`default_nettype wire

@@ design/psp_datapath.sv @@
// Datapath: item registers, point memory, serial divider, multiplier and result registers.
`default_nettype none
`include "piecewise_linear_setpoint_profile_defines.svh"
module psp_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psp_pkg::cmd_t      cmd,
	output psp_pkg::stat_t          stat,
	input  wire logic signed [15:0] cfg_min,
	input  wire logic signed [15:0] cfg_max,
	input  wire logic [2:0]         op,
	input  wire logic [3:0]         point_index,
	input  wire logic [19:0]        point_time,
	input  wire logic signed [15:0] point_temp,
	input  wire logic [4:0]         point_total,
	input  wire logic               end_mode_in,
	input  wire logic [31:0]        now_ms,
	output logic [2:0]              status,
	output logic                    run_on,
	output logic                    completed,
	output logic                    end_mode_out,
	output logic signed [15:0]      setpoint
);
	import psp_pkg::*;

	logic [2:0]         op_q;
	logic [3:0]         idx_q;
	logic [19:0]        ptime_q;
	logic signed [15:0] ptemp_q;
	logic [4:0]         total_q;
	logic               emode_q;
	logic [31:0]        now_q;

	logic [19:0]        tmem [MAX_POINTS];
	logic signed [15:0] cmem [MAX_POINTS];
	logic [19:0]        rd_time_s1;
	logic signed [15:0] rd_temp_s1;
	logic [IDX_W-1:0]   widx;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   used_q;
	logic               end_mode_q;
	logic               prof_q;
	logic               run_q;
	logic [31:0]        start_q;
	logic [19:0]        prev_time_q;
	logic signed [15:0] prev_temp_q;
	logic [ELAP_W-1:0]  elapsed_q;
	logic [31:0]        span_ms;
	logic [60:0]        elapsed_prod_s1;

	logic [DIVD_W-1:0]  quo_q;
	logic [DVSR_W:0]    rem_q;
	logic [DVSR_W-1:0]  dvsr_q;
	logic [DCNT_W-1:0]  dcnt_q;
	logic [DVSR_W:0]    rem_sh;
	logic               neg_q;

	logic signed [16:0] diff;
	logic [DVSR_W-1:0]  dt;
	logic signed [37:0] product_s1;
	logic [DIVD_W-1:0]  mag;
	logic signed [16:0] qsig;
	logic signed [16:0] interp;
	logic [CNT_W:0]     limit;

	logic [2:0]         res_status_q;
	logic               res_on_q;
	logic               res_done_q;
	logic               res_mode_q;
	logic signed [15:0] res_sp_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			idx_q   <= point_index;
			ptime_q <= point_time;
			ptemp_q <= point_temp;
			total_q <= point_total;
			emode_q <= end_mode_in;
			now_q   <= now_ms;
		end
	end

	assign widx = IDX_W'(idx_q);

	// Point store: written by a load, read at the scan counter.
	always_ff @(posedge clk) begin
		if (cmd.exec && op_q == OP_LOAD && int'(idx_q) < MAX_POINTS) begin
			tmem[widx] <= ptime_q;
			cmem[widx] <= ptemp_q;
		end
		if (cmd.rd) begin
			rd_time_s1 <= tmem[cnt_q[IDX_W-1:0]];
			rd_temp_s1 <= cmem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			used_q     <= '0;
			end_mode_q <= 1'b0;
			prof_q     <= 1'b0;
			run_q      <= 1'b0;
			start_q    <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.exec) begin
				unique case (op_q)
					OP_LOAD: begin
						prof_q <= 1'b0;
						run_q  <= 1'b0;
					end
					OP_DELETE: begin
						if (prof_q) begin
							prof_q <= 1'b0;
							run_q  <= 1'b0;
						end
					end
					OP_START: begin
						if (prof_q) begin
							run_q   <= 1'b1;
							start_q <= now_q;
						end
					end
					OP_CLEAR: begin
						run_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.c_ok) begin
				used_q     <= CNT_W'(total_q);
				end_mode_q <= emode_q;
				prof_q     <= 1'b1;
			end
		end
	end

	// Elapsed seconds by reciprocal multiplication of the wrapped millisecond span.
	assign span_ms = now_q - start_q;

	always_ff @(posedge clk) begin
		if (cmd.div_elapsed) begin
			elapsed_prod_s1 <= {29'd0, span_ms} * {32'd0, RECIP_1000};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			prev_time_q <= rd_time_s1;
			prev_temp_q <= rd_temp_s1;
		end
		if (cmd.elapsed_ld) begin
			elapsed_q <= elapsed_prod_s1[RECIP_SH +: ELAP_W];
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign rem_sh = {rem_q[DVSR_W-1:0], quo_q[DIVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_interp) begin
			dcnt_q <= DCNT_W'(DIV_STEPS);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_interp) begin
			quo_q  <= mag;
			dvsr_q <= rd_time_s1 - prev_time_q;
			rem_q  <= '0;
			neg_q  <= product_s1[37];
		end else if (dcnt_q != '0) begin
			if (rem_sh >= {1'b0, dvsr_q}) begin
				rem_q <= rem_sh - {1'b0, dvsr_q};
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	// Slope numerator: temperature step times seconds into the segment.
	assign diff = {rd_temp_s1[15], rd_temp_s1} - {prev_temp_q[15], prev_temp_q};
	assign dt   = DVSR_W'(elapsed_q - ELAP_W'(prev_time_q));
	assign mag  = product_s1[37] ? DIVD_W'(-product_s1) : DIVD_W'(product_s1);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			product_s1 <= diff * $signed({1'b0, dt});
		end
	end

	assign qsig   = $signed(quo_q[16:0]);
	assign interp = {prev_temp_q[15], prev_temp_q} + (neg_q ? -qsig : qsig);

	always_ff @(posedge clk) begin
		priority if (cmd.exec) begin
			res_on_q   <= 1'b0;
			res_done_q <= 1'b0;
			res_mode_q <= 1'b0;
			res_sp_q   <= '0;
			unique case (op_q)
				OP_COMMIT: res_status_q <= ST_FEW;
				OP_DELETE, OP_START: res_status_q <= prof_q ? ST_OK : ST_NOPROF;
				default: res_status_q <= ST_OK;
			endcase
		end else if (cmd.c_range || cmd.c_order || cmd.c_ok) begin
			res_on_q     <= 1'b0;
			res_done_q   <= 1'b0;
			res_mode_q   <= 1'b0;
			res_sp_q     <= '0;
			res_status_q <= cmd.c_range ? ST_RANGE : (cmd.c_order ? ST_ORDER : ST_OK);
		end else if (cmd.q_take || cmd.q_last || cmd.fin) begin
			res_status_q <= ST_OK;
			res_on_q     <= 1'b1;
			res_mode_q   <= end_mode_q;
			res_done_q   <= cmd.q_last;
			res_sp_q     <= cmd.fin ? interp[15:0] : rd_temp_s1;
		end else begin
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status       <= res_status_q;
			run_on       <= res_on_q;
			completed    <= res_done_q;
			end_mode_out <= res_mode_q;
			setpoint     <= res_sp_q;
		end
	end

	assign limit = (op_q == OP_COMMIT) ? (CNT_W + 1)'(total_q) : {1'b0, used_q};

	always_comb begin
		stat.op        = op_t'(op_q);
		stat.total_bad = (int'(total_q) < 2) || (int'(total_q) > MAX_POINTS);
		stat.run_ok    = run_q && (used_q != '0) && (int'(used_q) <= MAX_POINTS);
		stat.first     = (cnt_q == '0);
		stat.temp_bad  = (rd_temp_s1 < cfg_min) || (rd_temp_s1 > cfg_max);
		stat.le_prev   = (rd_time_s1 <= prev_time_q);
		stat.hit       = (elapsed_q <= ELAP_W'(rd_time_s1));
		stat.last      = ({1'b0, cnt_q} + 1'b1) >= limit;
		stat.div_busy  = (dcnt_q != '0);
	end

	`PSP_ASSERT_NEXT(a_div_runs, cmd.div_interp, stat.div_busy, "divider did not start")
	`PSP_ASSERT_SAME(a_cnt_in_range, 1'b1, int'(cnt_q) < MAX_POINTS, "scan counter past the store")
	`PSP_ASSERT_SAME(a_prof_used, prof_q, (int'(used_q) >= 2) && (int'(used_q) <= MAX_POINTS), "profile with bad point count")
endmodule
`default_nettype wire

@@ design/psp_ctrl.sv @@
// Controller: sequences each item through the datapath and owns the handshakes.
`default_nettype none
`include "piecewise_linear_setpoint_profile_defines.svh"
module psp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire psp_pkg::stat_t stat,
	output psp_pkg::cmd_t       cmd
);
	import psp_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.op == OP_COMMIT && !stat.total_bad) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_C_RD;
				end else if (stat.op == OP_QUERY && stat.run_ok) begin
					cmd.div_elapsed = 1'b1;
					state_d         = S_DIV_E;
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_DIV_E: begin
				// The reciprocal product registered in the execute state is ready here.
				cmd.elapsed_ld = 1'b1;
				cmd.cnt_clr    = 1'b1;
				state_d        = S_Q_RD;
			end
			S_Q_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_Q_CHK;
			end
			S_Q_CHK: begin
				if (stat.hit) begin
					if (stat.first || stat.le_prev) begin
						cmd.q_take = 1'b1;
						state_d    = S_DONE;
					end else begin
						cmd.mul = 1'b1;
						state_d = S_MUL;
					end
				end else if (stat.last) begin
					cmd.q_last = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_Q_RD;
				end
			end
			S_MUL: begin
				cmd.div_interp = 1'b1;
				state_d        = S_DIV_I;
			end
			S_DIV_I: begin
				if (!stat.div_busy) begin
					cmd.fin = 1'b1;
					state_d = S_DONE;
				end
			end
			S_C_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_C_CHK;
			end
			S_C_CHK: begin
				if (stat.temp_bad) begin
					cmd.c_range = 1'b1;
					state_d     = S_DONE;
				end else if (!stat.first && stat.le_prev) begin
					cmd.c_order = 1'b1;
					state_d     = S_DONE;
				end else if (stat.last) begin
					cmd.c_ok = 1'b1;
					state_d  = S_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_C_RD;
				end
			end
			S_DONE: begin
				if (!(out_valid && out_stall)) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`PSP_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_q == S_EXEC, "accepted word not executed")
	`PSP_ASSERT_SAME(a_rose_done, $rose(out_valid), $past(state_q == S_DONE), "result raised outside done")
	`PSP_ASSERT_SAME(a_chk_after_rd, state_q == S_C_CHK, $past(state_q == S_C_RD), "check without read")
endmodule
`default_nettype wire

@@ sim/piecewise_linear_setpoint_profile_test.sv @@
// Self-checking testbench of the piecewise-linear setpoint profile block.
`default_nettype none
module piecewise_linear_setpoint_profile_test;
	import psp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// One input word as it goes onto the payload ports.
	typedef struct {
		logic [2:0]         op;
		logic [3:0]         idx;
		logic [19:0]        ptime;
		logic signed [15:0] ptemp;
		logic [4:0]         total;
		logic               emode;
		logic [31:0]        now;
	} cmd_word_t;

	// One result word as the block should present it.
	typedef struct {
		logic [2:0]         status;
		logic               on;
		logic               done;
		logic               mode;
		logic signed [15:0] sp;
	} sp_result_t;

	logic               clk, arst_n;
	logic               psel, penable, pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;
	logic               in_valid, in_stall;
	logic [2:0]         op;
	logic [3:0]         point_index;
	logic [19:0]        point_time;
	logic signed [15:0] point_temp;
	logic [4:0]         point_total;
	logic               end_mode_in;
	logic [31:0]        now_ms;
	logic               out_valid, out_stall;
	logic [2:0]         status;
	logic               run_on, completed, end_mode_out;
	logic signed [15:0] setpoint;

	piecewise_linear_setpoint_profile dut (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Predictor state: our own copy of the profile, the run and the limits.
	logic [19:0]        mdl_times [MAX_POINTS];
	logic signed [15:0] mdl_temps [MAX_POINTS];
	int                 mdl_used;
	logic               mdl_mode, mdl_ok, mdl_run;
	logic [31:0]        mdl_start;
	int                 mdl_tmin, mdl_tmax;

	cmd_word_t  pending_words[$];
	sp_result_t expected_setpoints[$];
	int         errors;
	int         cycles;
	bit         quiet_phase;
	bit         hold_long;
	bit         stim_done;
	bit         took = 1'b0;

	// Point count first, then temperature range and strict time order, point by point.
	function automatic logic [2:0] commit_status(int total);
		if (total < 2 || total > MAX_POINTS) return ST_FEW;
		for (int i = 0; i < total; i++) begin
			if (mdl_temps[i] < mdl_tmin || mdl_temps[i] > mdl_tmax) return ST_RANGE;
			if (i > 0 && mdl_times[i] <= mdl_times[i-1]) return ST_ORDER;
		end
		return ST_OK;
	endfunction

	// Advance the predictor by one word and return what it should produce.
	function automatic sp_result_t apply_word(cmd_word_t w);
		sp_result_t r;
		logic [31:0] elapsed;
		longint diff, num, span;
		int k;
		r = '{ST_OK, 1'b0, 1'b0, 1'b0, 16'sd0};
		case (w.op)
			OP_LOAD: begin
				mdl_times[w.idx] = w.ptime;
				mdl_temps[w.idx] = w.ptemp;
				mdl_ok = 1'b0;
				mdl_run = 1'b0;
			end
			OP_COMMIT: begin
				r.status = commit_status(w.total);
				if (r.status == ST_OK) begin
					mdl_used = w.total;
					mdl_mode = w.emode;
					mdl_ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (mdl_ok) begin
					mdl_ok = 1'b0;
					mdl_run = 1'b0;
				end else r.status = ST_NOPROF;
			end
			OP_START: begin
				if (mdl_ok) begin
					mdl_run = 1'b1;
					mdl_start = w.now;
				end else r.status = ST_NOPROF;
			end
			OP_CLEAR: mdl_run = 1'b0;
			OP_QUERY: begin
				if (mdl_run && mdl_used >= 1) begin
					elapsed = (w.now - mdl_start) / 32'd1000;
					r.on = 1'b1;
					r.mode = mdl_mode;
					if (elapsed <= mdl_times[0]) r.sp = mdl_temps[0];
					else begin
						for (k = 1; k < mdl_used; k++) begin
							if (elapsed <= mdl_times[k]) break;
						end
						if (k >= mdl_used) begin
							r.done = 1'b1;
							r.sp = mdl_temps[mdl_used-1];
						end else if (mdl_times[k] <= mdl_times[k-1]) begin
							r.sp = mdl_temps[k];
						end else begin
							diff = longint'(mdl_temps[k]) - longint'(mdl_temps[k-1]);
							num = diff * longint'(elapsed - mdl_times[k-1]);
							span = longint'(mdl_times[k] - mdl_times[k-1]);
							r.sp = 16'(longint'(mdl_temps[k-1]) + num / span);
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// Driver: presents the oldest pending word, with random gaps in bursts.
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !took) begin
				// The word stays put while the block stalls it.
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(1, 19);
			end else if (pending_words.size() > 0) begin
				cmd_word_t w;
				w = pending_words[0];
				in_valid <= 1'b1;
				op <= w.op;
				point_index <= w.idx;
				point_time <= w.ptime;
				point_temp <= w.ptemp;
				point_total <= w.total;
				end_mode_in <= w.emode;
				now_ms <= w.now;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Predict on acceptance, seen at the rising edge, and retire the word from the queue.
	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			cmd_word_t w;
			w = '{op, point_index, point_time, point_temp, point_total, end_mode_in, now_ms};
			expected_setpoints.push_back(apply_word(w));
			pending_words.pop_front();
			took = 1'b1;
		end
	end

	// Receiver stall: random bursts, plus the long hold-off when asked.
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (hold_long) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 18);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sp_result_t e;
			if (expected_setpoints.size() == 0) begin
				$display("unexpected result at cycle %0d", cycles);
				errors++;
			end else begin
				e = expected_setpoints.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (run_on !== e.on) report_mismatch("run_on", run_on, e.on);
				if (completed !== e.done) report_mismatch("completed", completed, e.done);
				if (end_mode_out !== e.mode) report_mismatch("end_mode", end_mode_out, e.mode);
				if (setpoint !== e.sp) report_mismatch("setpoint", setpoint, e.sp);
			end
		end
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("piecewise_linear_setpoint_profile_test: FAIL");
			$finish;
		end
	end

	function automatic cmd_word_t mk(logic [2:0] o, int idx = 0, int t = 0, int tp = 0,
		int tot = 0, int em = 0, logic [31:0] n = 0);
		cmd_word_t w;
		w.op = o;
		w.idx = 4'(idx);
		w.ptime = 20'(t);
		w.ptemp = 16'(tp);
		w.total = 5'(tot);
		w.emode = 1'(em);
		w.now = n;
		return w;
	endfunction

	// Configuration writes go through the APB setup and access cycles.
	task automatic reg_write(reg_t r, int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * int'(r));
		pwdata <= 32'(value);
		mdl_tmin = (r == REG_TEMP_MIN) ? value : mdl_tmin;
		mdl_tmax = (r == REG_TEMP_MAX) ? value : mdl_tmax;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait for the block to drain, then a settling margin.
	task automatic drain;
		wait (pending_words.size() == 0 && !in_valid && expected_setpoints.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// A profile with random content, at times with a bad temperature or total; flaw allows repeated times.
	task automatic queue_profile(int n, bit flaw);
		int t;
		t = $urandom_range(0, 40);
		for (int i = 0; i < n; i++) begin
			pending_words.push_back(mk(OP_LOAD, i, t,
				$urandom_range(0, 9) == 0 ? int'($urandom_range(0, 65535)) - 32768
					: int'($urandom_range(0, 9600)) - 1600));
			t += (flaw && $urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 60);
		end
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0,
			$urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : n, $urandom_range(0, 1)));
	endtask

	task automatic queue_run(int nq);
		logic [31:0] base;
		base = $urandom;
		pending_words.push_back(mk(OP_START, 0, 0, 0, 0, 0, base));
		for (int q = 0; q < nq; q++) begin
			pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0,
				base + ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 900000))));
		end
	endtask

	initial begin
		int sent;
		cmd_word_t w;
		errors = 0;
		cycles = 0;
		quiet_phase = 1'b0;
		hold_long = 1'b0;
		stim_done = 1'b0;
		mdl_used = 0;
		mdl_mode = 1'b0;
		mdl_ok = 1'b0;
		mdl_run = 1'b0;
		mdl_start = '0;
		mdl_tmin = -1600;
		mdl_tmax = 8000;
		for (int i = 0; i < MAX_POINTS; i++) begin
			mdl_times[i] = '0;
			mdl_temps[i] = '0;
		end
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		op = '0;
		point_index = '0;
		point_time = '0;
		point_temp = '0;
		point_total = '0;
		end_mode_in = 1'b0;
		now_ms = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every point of the store is loaded first, so no commit reads an unwritten entry.
		for (int i = 0; i < MAX_POINTS; i++) begin
			pending_words.push_back(mk(OP_LOAD, i, i, 0));
		end

		// Directed: no-profile cases, unused codes, extremes of every field.
		pending_words.push_back(mk(OP_DELETE));
		pending_words.push_back(mk(OP_START, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		pending_words.push_back(mk(OP_QUERY));
		pending_words.push_back(mk(3'd6, 15, 20'hFFFFF, -1, 31, 1, 32'hFFFF_FFFF));
		pending_words.push_back(mk(3'd7));
		pending_words.push_back(mk(OP_LOAD, 0, 5, -1600));
		pending_words.push_back(mk(OP_LOAD, 1, 10, 8000));
		pending_words.push_back(mk(OP_LOAD, 2, 20'hFFFFF, 100));
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 1));
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 17));
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 3, 1));
		pending_words.push_back(mk(OP_START, 0, 0, 0, 0, 0, 32'hFFFF_F000));
		pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'd2000));
		pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'd7000));
		pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'hFFFF_EFFF));
		pending_words.push_back(mk(OP_CLEAR));
		pending_words.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 32'd7000));
		pending_words.push_back(mk(OP_LOAD, 1, 5, -32768));
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 3));
		pending_words.push_back(mk(OP_LOAD, 1, 10, 32767));
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 3));
		pending_words.push_back(mk(OP_DELETE));
		drain();

		// Inverted and extreme limits, then back to a wide window.
		reg_write(REG_TEMP_MIN, 100);
		reg_write(REG_TEMP_MAX, -100);
		pending_words.push_back(mk(OP_COMMIT, 0, 0, 0, 3));
		drain();
		reg_write(REG_TEMP_MIN, -32768);
		reg_write(REG_TEMP_MAX, 32767);

		// Random phases, with the limits changed between them.
		sent = 0;
		for (int phase = 0; sent < 1950; phase++) begin
			int queued_before;
			if (phase == 3) begin
				// Hold the output off while words keep coming, so the block backs up.
				fork
					begin
						#1;
						hold_long = 1'b1;
						repeat (600) @(posedge clk);
						hold_long = 1'b0;
					end
				join_none
			end
			if (phase > 0 && phase % 6 == 0) begin
				drain();
				reg_write(REG_TEMP_MIN, int'($urandom_range(0, 4000)) - 3000);
				reg_write(REG_TEMP_MAX, int'($urandom_range(0, 40000)) - 8000);
			end
			queued_before = pending_words.size();
			if (sent > 1750) quiet_phase = 1'b1;
			for (int j = 0; j < 8; j++) begin
				case ($urandom_range(0, 9))
					0: pending_words.push_back(mk(3'($urandom), $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom));
					1: pending_words.push_back(mk(OP_DELETE));
					2: queue_profile($urandom_range(2, 3), 1'b1);
					3: queue_profile(MAX_POINTS, 1'b0);
					default: begin
						queue_profile($urandom_range(2, 5), 1'b0);
						queue_run($urandom_range(2, 8));
						if ($urandom_range(0, 3) == 0) pending_words.push_back(mk(OP_CLEAR));
					end
				endcase
			end
			sent += pending_words.size() - queued_before;
			wait (pending_words.size() < 40);
		end
		stim_done = 1'b1;
		wait (pending_words.size() == 0 && !in_valid);
		wait (expected_setpoints.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("piecewise_linear_setpoint_profile_test: PASS");
		end else begin
			$display("piecewise_linear_setpoint_profile_test: FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ piecewise_linear_setpoint_profile.f @@
+incdir+design
design/psp_pkg.sv
design/psp_datapath.sv
design/psp_ctrl.sv
design/piecewise_linear_setpoint_profile.sv
sim/piecewise_linear_setpoint_profile_test.sv
